[sv/bls_pkg.sv]
// Shared types and constants for the Bresenham line stepper.
`default_nettype none

package bls_pkg;

    localparam int COORD_BITS = 12;
    localparam int COLOR_BITS = 24;
    localparam int DEC_BITS   = COORD_BITS + 3;

    typedef logic [COORD_BITS-1:0]      t_coord;
    typedef logic [COLOR_BITS-1:0]      t_color;
    typedef logic signed [DEC_BITS-1:0] t_dec;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_STEP = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode  mode;
        t_coord x_start;
        t_coord y_start;
        t_coord x_end;
        t_coord y_end;
        t_color color;
    } t_cmd;

    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        t_color pixel_color;
        logic   last_pixel;
    } t_pixel;

endpackage

`default_nettype wire

[sv/bls_ifs.sv]
// Valid/ready channel interfaces for command and pixel transactions.
`default_nettype none

interface bls_cmd_if;
    logic          valid;
    logic          ready;
    bls_pkg::t_cmd data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bls_pix_if;
    logic            valid;
    logic            ready;
    bls_pkg::t_pixel data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/bls_engine.sv]
// Line state registers and the per-transaction load/step logic.
`default_nettype none

module bls_engine (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire bls_pkg::t_cmd   i_cmd,
    output logic                 o_res_valid,
    output bls_pkg::t_pixel      o_res
);

    logic            r_active, n_active;
    logic            r_steep, n_steep;
    logic            r_ydesc, n_ydesc;
    bls_pkg::t_coord r_cur_x, n_cur_x;
    bls_pkg::t_coord r_cur_y, n_cur_y;
    bls_pkg::t_coord r_major_end, n_major_end;
    bls_pkg::t_coord r_major_span, n_major_span;
    bls_pkg::t_coord r_minor_span, n_minor_span;
    bls_pkg::t_dec   r_decision, n_decision;
    bls_pkg::t_color r_color, n_color;

    // load path
    logic            swap;
    bls_pkg::t_coord ax, ay, bx, by;
    bls_pkg::t_coord dx, ady;
    logic            ld_ydesc, ld_steep;
    bls_pkg::t_coord ld_major, ld_minor, ld_major_end;
    bls_pkg::t_dec   ld_decision;

    always_comb begin
        swap     = i_cmd.x_end < i_cmd.x_start;
        ax       = swap ? i_cmd.x_end : i_cmd.x_start;
        ay       = swap ? i_cmd.y_end : i_cmd.y_start;
        bx       = swap ? i_cmd.x_start : i_cmd.x_end;
        by       = swap ? i_cmd.y_start : i_cmd.y_end;
        dx       = bx - ax;
        ld_ydesc = by < ay;
        ady      = ld_ydesc ? (ay - by) : (by - ay);
        ld_steep = !(dx > ady);
        ld_major     = ld_steep ? ady : dx;
        ld_minor     = ld_steep ? dx : ady;
        ld_major_end = ld_steep ? by : bx;
        ld_decision  = bls_pkg::t_dec'(ld_major) - (bls_pkg::t_dec'(ld_minor) <<< 1);
    end

    // step path
    logic            minor_step;
    bls_pkg::t_dec   dec_minor, dec_major;
    bls_pkg::t_coord x_inc, y_adv;
    bls_pkg::t_coord st_x, st_y, major_now;

    always_comb begin
        minor_step = r_decision[bls_pkg::DEC_BITS-1] || (r_decision == '0);
        dec_minor  = r_decision + ((bls_pkg::t_dec'(r_major_span)
                                    - bls_pkg::t_dec'(r_minor_span)) <<< 1);
        dec_major  = r_decision - (bls_pkg::t_dec'(r_minor_span) <<< 1);
        x_inc      = r_cur_x + bls_pkg::t_coord'(1);
        y_adv      = r_ydesc ? (r_cur_y - bls_pkg::t_coord'(1))
                             : (r_cur_y + bls_pkg::t_coord'(1));
        if (r_steep) begin
            st_x      = minor_step ? x_inc : r_cur_x;
            st_y      = y_adv;
            major_now = y_adv;
        end else begin
            st_x      = x_inc;
            st_y      = minor_step ? y_adv : r_cur_y;
            major_now = x_inc;
        end
    end

    always_comb begin
        n_active     = r_active;
        n_steep      = r_steep;
        n_ydesc      = r_ydesc;
        n_cur_x      = r_cur_x;
        n_cur_y      = r_cur_y;
        n_major_end  = r_major_end;
        n_major_span = r_major_span;
        n_minor_span = r_minor_span;
        n_decision   = r_decision;
        n_color      = r_color;
        o_res_valid  = 1'b0;
        o_res.pixel_x     = st_x;
        o_res.pixel_y     = st_y;
        o_res.pixel_color = r_color;
        o_res.last_pixel  = (major_now == r_major_end);
        if (i_accept) begin
            if (i_cmd.mode == bls_pkg::MODE_LOAD) begin
                n_active     = (ld_major != '0);
                n_steep      = ld_steep;
                n_ydesc      = ld_ydesc;
                n_cur_x      = ax;
                n_cur_y      = ay;
                n_major_end  = ld_major_end;
                n_major_span = ld_major;
                n_minor_span = ld_minor;
                n_decision   = ld_decision;
                n_color      = i_cmd.color;
            end else if (r_active) begin
                o_res_valid = 1'b1;
                n_cur_x     = st_x;
                n_cur_y     = st_y;
                n_decision  = minor_step ? dec_minor : dec_major;
                n_active    = (major_now != r_major_end);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_steep  <= 1'b0;
            r_ydesc  <= 1'b0;
        end else begin
            r_active <= n_active;
            r_steep  <= n_steep;
            r_ydesc  <= n_ydesc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_x      <= n_cur_x;
        r_cur_y      <= n_cur_y;
        r_major_end  <= n_major_end;
        r_major_span <= n_major_span;
        r_minor_span <= n_minor_span;
        r_decision   <= n_decision;
        r_color      <= n_color;
    end

endmodule

`default_nettype wire

[sv/bresenham_line_stepper_core.sv]
// Top level: command intake and registered pixel output of the line stepper.
// Latency: a step transaction's pixel is valid on o_pix the cycle after acceptance.
// Throughput: one command transaction per cycle; it stalls only while a pixel waits.
// A load gives no pixel; a step while idle gives no pixel.
// Synchronous active-low reset returns the stepper to idle with an empty output.
`default_nettype none

module bresenham_line_stepper_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bls_cmd_if.sink    i_cmd,
    bls_pix_if.source  o_pix
);

    logic            accept;
    logic            res_valid;
    bls_pkg::t_pixel res;
    logic            r_out_valid, n_out_valid;
    bls_pkg::t_pixel r_out;

    assign i_cmd.ready = !r_out_valid || o_pix.ready;
    assign accept      = i_cmd.valid && i_cmd.ready;

    bls_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_cmd       (i_cmd.data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_comb begin
        priority if (accept && res_valid) begin
            n_out_valid = 1'b1;
        end else if (o_pix.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && res_valid) begin
            r_out <= res;
        end
    end

    assign o_pix.valid = r_out_valid;
    assign o_pix.data  = r_out;

endmodule

`default_nettype wire
